[rtl/csu_pkg.sv]
// ----------------------------------------------------------------------------
// csu_pkg: shared types and constants for the cursor sprite save-under block
// Function codes, register indexes, register reset values, the configuration
// bundle and the built-in hand cursor table.
// ----------------------------------------------------------------------------
package csu_pkg;

   // Default sprite height in rows
   localparam int SPRITE_ROWS_DEF = 16;

   // Field widths fixed by the interface
   localparam int CSR_IDX_W = 3;
   localparam int FUNC_W    = 2;

   // Item function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RDRSP   = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BASE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOTSPOT_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOTSPOT_Y     = 3'd5;

   // Register reset values
   localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd512;
   localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd342;
   localparam logic [13:0] RST_ROW_STRIDE    = 14'd64;
   localparam logic [31:0] RST_FRAME_BASE    = 32'd0;
   localparam logic [3:0]  RST_HOTSPOT_X     = 4'd1;
   localparam logic [3:0]  RST_HOTSPOT_Y     = 4'd1;

   // Configuration bundle from the register file to the datapath
   typedef struct packed {
      logic [11:0] screen_width;
      logic [11:0] screen_height;
      logic [13:0] row_stride;
      logic [31:0] frame_base;
      logic [3:0]  hotspot_x;
      logic [3:0]  hotspot_y;
   } cfg_type;

   // Built-in hand cursor: {image, mask} per row, zero past the sixteenth row
   function automatic logic [31:0] hand_row(input logic [5:0] idx);
      logic [31:0] val;
      case (idx)
         6'd0:    val = {16'h0000, 16'hC000};
         6'd1:    val = {16'h4000, 16'hE000};
         6'd2:    val = {16'h6000, 16'hF000};
         6'd3:    val = {16'h7000, 16'hF800};
         6'd4:    val = {16'h7800, 16'hFC00};
         6'd5:    val = {16'h7C00, 16'hFE00};
         6'd6:    val = {16'h7E00, 16'hFF00};
         6'd7:    val = {16'h7F00, 16'hFF80};
         6'd8:    val = {16'h7F80, 16'hFFC0};
         6'd9:    val = {16'h7C00, 16'hFFE0};
         6'd10:   val = {16'h6C00, 16'hFE00};
         6'd11:   val = {16'h4600, 16'hEF00};
         6'd12:   val = {16'h0600, 16'hCF00};
         6'd13:   val = {16'h0300, 16'h8780};
         6'd14:   val = {16'h0300, 16'h0780};
         6'd15:   val = {16'h0000, 16'h0380};
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

[rtl/csu_ram.sv]
// ----------------------------------------------------------------------------
// csu_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered and appears in the
// cycle after the address.
// ----------------------------------------------------------------------------
module csu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/csu_csr.sv]
// ----------------------------------------------------------------------------
// csu_csr: configuration register file
// Takes one register write per transfer on the csr channel and presents the
// current settings as one bundle.
// ----------------------------------------------------------------------------
module csu_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [csu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output csu_pkg::cfg_type              cfg
);
   import csu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[11:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[11:0];
            CSR_ROW_STRIDE:    cfg_in.row_stride    = csr_data[13:0];
            CSR_FRAME_BASE:    cfg_in.frame_base    = csr_data;
            CSR_HOTSPOT_X:     cfg_in.hotspot_x     = csr_data[3:0];
            CSR_HOTSPOT_Y:     cfg_in.hotspot_y     = csr_data[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.row_stride    <= RST_ROW_STRIDE;
         cfg_ff.frame_base    <= RST_FRAME_BASE;
         cfg_ff.hotspot_x     <= RST_HOTSPOT_X;
         cfg_ff.hotspot_y     <= RST_HOTSPOT_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

[rtl/csu_sprite.sv]
// ----------------------------------------------------------------------------
// csu_sprite: cursor image and mask store
// RAM of {image, mask} rows with a valid bit per row; a row never loaded
// since reset reads as the built-in hand cursor.
// ----------------------------------------------------------------------------
module csu_sprite #(
   parameter int SPRITE_ROWS = csu_pkg::SPRITE_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(SPRITE_ROWS)-1:0] wr_row,
   input  logic [15:0]                    wr_image,
   input  logic [15:0]                    wr_mask,
   input  logic [$clog2(SPRITE_ROWS)-1:0] rd_row,
   output logic [15:0]                    rd_image,
   output logic [15:0]                    rd_mask
);
   import csu_pkg::*;

   localparam int RW = $clog2(SPRITE_ROWS);

   logic [SPRITE_ROWS-1:0] vld_ff;
   logic [SPRITE_ROWS-1:0] vld_in;
   logic                   rd_vld_ff;
   logic [RW-1:0]          rd_row_ff;
   logic [31:0]            ram_q;
   logic [31:0]            row_q;

   csu_ram #(
      .WIDTH (32),
      .DEPTH (SPRITE_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row),
      .wr_data ({wr_image, wr_mask}),
      .rd_addr (rd_row),
      .rd_data (ram_q)
   );

   // Row valid bits
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[rd_row];
      end
      rd_row_ff <= rd_row;
   end

   // Unloaded rows fall back to the built-in table
   assign row_q    = rd_vld_ff ? ram_q : hand_row(6'(rd_row_ff));
   assign rd_image = row_q[31:16];
   assign rd_mask  = row_q[15:0];

endmodule

[rtl/cursor_sprite_save_under.sv]
// ----------------------------------------------------------------------------
// cursor_sprite_save_under: software cursor blit with save-under
// Draws a 16-pixel-wide one-bit cursor into a framebuffer through memory
// requests, keeps the words it covers and puts them back on restore.
// ----------------------------------------------------------------------------
// Usage:
//  Items enter on req_* at a clock edge with start high and busy low.
//  Requests leave on rsp_* for one cycle each, marked by rsp_strobe; the
//  receiver takes every request and cannot stall the block.
//  The user writes registers over csr_* (always ready) only while idle; the block does not enforce it.
//  Load: no request and never busy; the next item may follow at once.
//  Draw: busy through ST_DRAW_OFF, ST_DRAW_ADDR and ST_DRAW_EMIT; the read requests
//   leave registered from ST_DRAW_EMIT, one read per cycle, last on the final one.
//   The address product (ST_DRAW_OFF) and base add (ST_DRAW_ADDR) come before the run.
//  Read response: busy for one cycle in ST_RESP, which forms its write request;
//   no new response is taken until it ends. A response with no read outstanding
//   is dropped without going busy.
//  Restore: ST_REST reads each saved row from the save RAM, then ST_REST_LAST
//   ends busy; writes go out one per cycle, after the registered RAM read.
//   With nothing saved it sends nothing and does not go busy.
//  Reset: registers take their defaults, the cursor is the built-in hand,
//   nothing is saved and no read is outstanding.
// ----------------------------------------------------------------------------
module cursor_sprite_save_under #(
   parameter int SPRITE_ROWS = csu_pkg::SPRITE_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // item channel
   input  logic                          start,
   output logic                          busy,
   input  logic [csu_pkg::FUNC_W-1:0]    req_func,
   input  logic [3:0]                    req_row_index,
   input  logic [15:0]                   req_row_image,
   input  logic [15:0]                   req_row_mask,
   input  logic signed [15:0]            req_mouse_x,
   input  logic signed [15:0]            req_mouse_y,
   input  logic [31:0]                   req_read_word,
   // request channel
   output logic                          rsp_strobe,
   output logic                          rsp_is_write,
   output logic [31:0]                   rsp_address,
   output logic [31:0]                   rsp_write_word,
   output logic                          rsp_last,
   // register channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [csu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import csu_pkg::*;

   localparam int RW = $clog2(SPRITE_ROWS);
   localparam int CW = $clog2(SPRITE_ROWS + 1);
   localparam logic [CW-1:0] ROWS_C   = CW'(SPRITE_ROWS);
   localparam logic [CW-1:0] LAST_C   = CW'(SPRITE_ROWS - 1);
   localparam logic [11:0]   ROWS_Y   = 12'(SPRITE_ROWS);
   localparam logic [5:0]    ROWS_LD  = 6'(SPRITE_ROWS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW_OFF,
      ST_DRAW_ADDR,
      ST_DRAW_EMIT,
      ST_RESP,
      ST_REST,
      ST_REST_LAST
   } state_type;

   cfg_type cfg;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic [CW-1:0] rend_ff, rend_in;
   logic          svalid_ff, svalid_in;
   logic [3:0]    shift_ff, shift_in;
   logic [31:0]   saddr_ff, saddr_in;
   logic [11:0]   xc_ff, xc_in;
   logic [11:0]   yc_ff, yc_in;
   logic [26:0]   off_ff, off_in;
   logic [31:0]   word_ff, word_in;
   logic          rpipe_ff, rpipe_in;
   logic [RW-1:0] rrow_ff, rrow_in;
   logic          rlast_ff, rlast_in;
   logic          strobe_ff, strobe_in;
   logic          iswr_ff, iswr_in;
   logic [31:0]   addr_ff, addr_in;
   logic [31:0]   wword_ff, wword_in;
   logic          last_ff, last_in;

   logic          accept;
   logic [16:0]   x_diff, y_diff;
   logic [11:0]   x_lim, y_lim;
   logic [11:0]   x_clamp, y_clamp;
   logic [RW-1:0] emit_row;
   logic [31:0]   row_addr;
   logic [15:0]   spr_img, spr_msk;
   logic [31:0]   img_sh, msk_sh;
   logic [31:0]   sav_q;
   logic          spr_wr, sav_wr;

   csu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   csu_sprite #(
      .SPRITE_ROWS (SPRITE_ROWS)
   ) u_sprite (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (spr_wr),
      .wr_row   (RW'(req_row_index)),
      .wr_image (req_row_image),
      .wr_mask  (req_row_mask),
      .rd_row   (pend_ff[RW-1:0]),
      .rd_image (spr_img),
      .rd_mask  (spr_msk)
   );

   // Save-under store: written by read responses, read back by restore
   csu_ram #(
      .WIDTH (32),
      .DEPTH (SPRITE_ROWS)
   ) u_save (
      .clock   (clock),
      .wr_en   (sav_wr),
      .wr_addr (pend_ff[RW-1:0]),
      .wr_data (req_read_word),
      .rd_addr (cnt_ff[RW-1:0]),
      .rd_data (sav_q)
   );

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign spr_wr = accept && (req_func == FUNC_LOAD) && ({2'b00, req_row_index} < ROWS_LD);
   assign sav_wr = accept && (req_func == FUNC_RDRSP) && (pend_ff < ROWS_C);

   // Cursor position less hotspot, clamped to the screen
   assign x_diff = {req_mouse_x[15], req_mouse_x} - {13'd0, cfg.hotspot_x};
   assign y_diff = {req_mouse_y[15], req_mouse_y} - {13'd0, cfg.hotspot_y};
   assign x_lim  = (cfg.screen_width > 12'd16) ? cfg.screen_width - 12'd16 : 12'd0;
   assign y_lim  = (cfg.screen_height > ROWS_Y) ? cfg.screen_height - ROWS_Y : 12'd0;

   always_comb begin
      if (x_diff[16]) begin
         x_clamp = 12'd0;
      end else if (x_diff[15:0] > {4'd0, x_lim}) begin
         x_clamp = x_lim;
      end else begin
         x_clamp = x_diff[11:0];
      end
      if (y_diff[16]) begin
         y_clamp = 12'd0;
      end else if (y_diff[15:0] > {4'd0, y_lim}) begin
         y_clamp = y_lim;
      end else begin
         y_clamp = y_diff[11:0];
      end
   end

   // Row address: saved base plus row times current stride
   always_comb begin
      case (state_ff)
         ST_DRAW_EMIT: emit_row = cnt_ff[RW-1:0];
         ST_RESP:      emit_row = pend_ff[RW-1:0];
         default:      emit_row = rrow_ff;
      endcase
   end

   assign row_addr = saddr_ff + 32'(emit_row * cfg.row_stride);

   // Sprite row aligned to the pixel shift
   assign img_sh = {spr_img, 16'h0000} >> shift_ff;
   assign msk_sh = {spr_msk, 16'h0000} >> shift_ff;

   // Sequencer and request datapath
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      rend_in   = rend_ff;
      svalid_in = svalid_ff;
      shift_in  = shift_ff;
      saddr_in  = saddr_ff;
      xc_in     = xc_ff;
      yc_in     = yc_ff;
      off_in    = off_ff;
      word_in   = word_ff;
      rpipe_in  = 1'b0;
      rrow_in   = rrow_ff;
      rlast_in  = rlast_ff;
      strobe_in = 1'b0;
      iswr_in   = iswr_ff;
      addr_in   = addr_ff;
      wword_in  = wword_ff;
      last_in   = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_DRAW: begin
                     xc_in     = x_clamp;
                     yc_in     = y_clamp;
                     svalid_in = 1'b0;
                     pend_in   = '0;
                     state_in  = ST_DRAW_OFF;
                  end
                  FUNC_RESTORE: begin
                     if (svalid_ff) begin
                        rend_in   = ((pend_ff < ROWS_C) ? pend_ff : ROWS_C) - CW'(1);
                        cnt_in    = '0;
                        svalid_in = 1'b0;
                        pend_in   = ROWS_C;
                        state_in  = ST_REST;
                     end
                  end
                  FUNC_RDRSP: begin
                     if (pend_ff < ROWS_C) begin
                        word_in  = req_read_word;
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DRAW_OFF: begin
            off_in   = 27'(yc_ff * cfg.row_stride) + 27'(xc_ff[11:3]);
            shift_in = xc_ff[3:0];
            state_in = ST_DRAW_ADDR;
         end
         ST_DRAW_ADDR: begin
            saddr_in = cfg.frame_base + {5'd0, off_ff[26:1], 1'b0};
            cnt_in   = '0;
            state_in = ST_DRAW_EMIT;
         end
         ST_DRAW_EMIT: begin
            strobe_in = 1'b1;
            iswr_in   = 1'b0;
            addr_in   = row_addr;
            wword_in  = 32'd0;
            last_in   = (cnt_ff == LAST_C);
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == LAST_C) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            strobe_in = 1'b1;
            iswr_in   = 1'b1;
            addr_in   = row_addr;
            wword_in  = (word_ff & ~msk_sh) | img_sh;
            last_in   = (pend_ff == LAST_C);
            pend_in   = pend_ff + CW'(1);
            svalid_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_REST: begin
            rpipe_in = 1'b1;
            rrow_in  = cnt_ff[RW-1:0];
            rlast_in = (cnt_ff == rend_ff);
            cnt_in   = cnt_ff + CW'(1);
            if (cnt_ff == rend_ff) begin
               state_in = ST_REST_LAST;
            end
         end
         ST_REST_LAST: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Restore write for the row read last cycle
      if (rpipe_ff) begin
         strobe_in = 1'b1;
         iswr_in   = 1'b1;
         addr_in   = row_addr;
         wword_in  = sav_q;
         last_in   = rlast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= ROWS_C;
         svalid_ff <= 1'b0;
         shift_ff  <= 4'd0;
         saddr_ff  <= 32'd0;
         rpipe_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         svalid_ff <= svalid_in;
         shift_ff  <= shift_in;
         saddr_ff  <= saddr_in;
         rpipe_ff  <= rpipe_in;
         strobe_ff <= strobe_in;
      end
      cnt_ff   <= cnt_in;
      rend_ff  <= rend_in;
      xc_ff    <= xc_in;
      yc_ff    <= yc_in;
      off_ff   <= off_in;
      word_ff  <= word_in;
      rrow_ff  <= rrow_in;
      rlast_ff <= rlast_in;
      iswr_ff  <= iswr_in;
      addr_ff  <= addr_in;
      wword_ff <= wword_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_is_write   = iswr_ff;
   assign rsp_address    = addr_ff;
   assign rsp_write_word = wword_ff;
   assign rsp_last       = last_ff;

endmodule

[tb/csu_request_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csu_request_checker: memory request predictor for the cursor save-under block
// Watches the item, register and request channels, keeps its own copy of the
// sprite, save store and registers, predicts every memory request and
// compares each strobed request field by field in order.
// ----------------------------------------------------------------------------
module csu_request_checker #(
   parameter int SPRITE_ROWS = csu_pkg::SPRITE_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [csu_pkg::FUNC_W-1:0]    req_func,
   input  logic [3:0]                    req_row_index,
   input  logic [15:0]                   req_row_image,
   input  logic [15:0]                   req_row_mask,
   input  logic signed [15:0]            req_mouse_x,
   input  logic signed [15:0]            req_mouse_y,
   input  logic [31:0]                   req_read_word,
   input  logic                          rsp_strobe,
   input  logic                          rsp_is_write,
   input  logic [31:0]                   rsp_address,
   input  logic [31:0]                   rsp_write_word,
   input  logic                          rsp_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [csu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   import csu_pkg::*;

   typedef struct packed {
      logic        is_write;
      logic [31:0] address;
      logic [31:0] write_word;
      logic        last;
   } mem_request_type;

   // Built-in hand cursor, image and mask per row
   localparam logic [0:15][15:0] HAND_IMAGE = {
      16'h0000, 16'h4000, 16'h6000, 16'h7000, 16'h7800, 16'h7C00, 16'h7E00, 16'h7F00,
      16'h7F80, 16'h7C00, 16'h6C00, 16'h4600, 16'h0600, 16'h0300, 16'h0300, 16'h0000};
   localparam logic [0:15][15:0] HAND_MASK = {
      16'hC000, 16'hE000, 16'hF000, 16'hF800, 16'hFC00, 16'hFE00, 16'hFF00, 16'hFF80,
      16'hFFC0, 16'hFFE0, 16'hFE00, 16'hEF00, 16'hCF00, 16'h8780, 16'h0780, 16'h0380};

   mem_request_type expected_requests[$];
   cfg_type         cfg;
   logic [15:0]     image_rows [SPRITE_ROWS];
   logic [15:0]     mask_rows  [SPRITE_ROWS];
   logic [31:0]     saved_words[SPRITE_ROWS];
   logic [31:0]     saved_addr;
   logic            saved_valid;
   int              pending_row;
   logic [3:0]      pixel_shift;

   // Clamp a cursor coordinate to 0..extent-size, zero when the screen is small
   function automatic int clamp_coord(input int v, input int extent, input int size);
      int lim;
      lim = (extent > size) ? extent - size : 0;
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", field, want, got);
         fail_count++;
      end
   endtask

   // Update the predicted state for one accepted item and queue its requests
   task automatic predict_item();
      int              pos_x, pos_y, r, count;
      logic [31:0]     stride32, offset, img, msk, row_addr;
      mem_request_type req;
      stride32 = {18'd0, cfg.row_stride};
      case (req_func)
         FUNC_LOAD: begin
            if (int'(req_row_index) < SPRITE_ROWS) begin
               image_rows[req_row_index] = req_row_image;
               mask_rows[req_row_index]  = req_row_mask;
            end
         end
         FUNC_DRAW: begin
            pos_x = clamp_coord(int'(req_mouse_x) - int'(cfg.hotspot_x),
                                int'(cfg.screen_width), 16);
            pos_y = clamp_coord(int'(req_mouse_y) - int'(cfg.hotspot_y),
                                int'(cfg.screen_height), SPRITE_ROWS);
            offset = (32'(pos_y) * stride32 + 32'(pos_x >> 3)) & ~32'd1;
            saved_addr  = cfg.frame_base + offset;
            pixel_shift = pos_x[3:0];
            saved_valid = 1'b0;
            pending_row = 0;
            for (r = 0; r < SPRITE_ROWS; r++) begin
               req.is_write   = 1'b0;
               req.address    = saved_addr + 32'(r) * stride32;
               req.write_word = 32'd0;
               req.last       = (r == SPRITE_ROWS - 1);
               expected_requests.push_back(req);
            end
         end
         FUNC_RESTORE: begin
            if (saved_valid) begin
               count = (pending_row < SPRITE_ROWS) ? pending_row : SPRITE_ROWS;
               for (r = 0; r < count; r++) begin
                  req.is_write   = 1'b1;
                  req.address    = saved_addr + 32'(r) * stride32;
                  req.write_word = saved_words[r];
                  req.last       = (r == count - 1);
                  expected_requests.push_back(req);
               end
               saved_valid = 1'b0;
               pending_row = SPRITE_ROWS;
            end
         end
         default: begin
            // read response: merge the cursor row into the returned word
            if (pending_row < SPRITE_ROWS) begin
               img = {image_rows[pending_row], 16'd0} >> pixel_shift;
               msk = {mask_rows[pending_row], 16'd0} >> pixel_shift;
               row_addr = saved_addr + 32'(pending_row) * stride32;
               saved_words[pending_row] = req_read_word;
               saved_valid    = 1'b1;
               req.is_write   = 1'b1;
               req.address    = row_addr;
               req.write_word = (req_read_word & ~msk) | img;
               req.last       = (pending_row == SPRITE_ROWS - 1);
               expected_requests.push_back(req);
               pending_row++;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      mem_request_type want;
      if (reset) begin
         cfg.screen_width  = RST_SCREEN_WIDTH;
         cfg.screen_height = RST_SCREEN_HEIGHT;
         cfg.row_stride    = RST_ROW_STRIDE;
         cfg.frame_base    = RST_FRAME_BASE;
         cfg.hotspot_x     = RST_HOTSPOT_X;
         cfg.hotspot_y     = RST_HOTSPOT_Y;
         for (int i = 0; i < SPRITE_ROWS; i++) begin
            image_rows[i]  = (i < 16) ? HAND_IMAGE[i] : 16'd0;
            mask_rows[i]   = (i < 16) ? HAND_MASK[i] : 16'd0;
            saved_words[i] = 32'd0;
         end
         saved_addr  = 32'd0;
         saved_valid = 1'b0;
         pending_row = SPRITE_ROWS;
         pixel_shift = 4'd0;
         expected_requests.delete();
      end else begin
         // strobed request against the oldest prediction
         if (rsp_strobe) begin
            if (expected_requests.size() == 0) begin
               $error("unexpected request: address %h, write %b", rsp_address, rsp_is_write);
               fail_count++;
            end else begin
               want = expected_requests.pop_front();
               check_field("is_write", 32'(want.is_write), 32'(rsp_is_write));
               check_field("address", want.address, rsp_address);
               check_field("write_word", want.write_word, rsp_write_word);
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  cfg.screen_width  = csr_data[11:0];
               CSR_SCREEN_HEIGHT: cfg.screen_height = csr_data[11:0];
               CSR_ROW_STRIDE:    cfg.row_stride    = csr_data[13:0];
               CSR_FRAME_BASE:    cfg.frame_base    = csr_data;
               CSR_HOTSPOT_X:     cfg.hotspot_x     = csr_data[3:0];
               CSR_HOTSPOT_Y:     cfg.hotspot_y     = csr_data[3:0];
               default: ;
            endcase
         end
         // item transfer
         if (start && !busy) predict_item();
      end
      pending_count <= expected_requests.size();
   end

endmodule

[tb/cursor_sprite_save_under_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_sprite_save_under_tb: stimulus and verdict for the save-under block
// Runs directed and random item streams (draw, read responses, restore,
// cursor loads and noise) under several register settings and sender idling
// patterns; the request checker predicts and compares every memory request.
// ----------------------------------------------------------------------------
module cursor_sprite_save_under_tb;
   import csu_pkg::*;

   localparam int ROWS = SPRITE_ROWS_DEF;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func;
   logic [3:0]           req_row_index;
   logic [15:0]          req_row_image;
   logic [15:0]          req_row_mask;
   logic signed [15:0]   req_mouse_x;
   logic signed [15:0]   req_mouse_y;
   logic [31:0]          req_read_word;
   logic                 rsp_strobe;
   logic                 rsp_is_write;
   logic [31:0]          rsp_address;
   logic [31:0]          rsp_write_word;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;
   int                   fail_count;
   int                   pending_count;

   int idle_pct;
   int cur_width;
   int cur_height;

   cursor_sprite_save_under uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_row_index(req_row_index),
      .req_row_image(req_row_image), .req_row_mask(req_row_mask),
      .req_mouse_x(req_mouse_x), .req_mouse_y(req_mouse_y),
      .req_read_word(req_read_word),
      .rsp_strobe(rsp_strobe), .rsp_is_write(rsp_is_write),
      .rsp_address(rsp_address), .rsp_write_word(rsp_write_word),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   csu_request_checker req_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_row_index(req_row_index),
      .req_row_image(req_row_image), .req_row_mask(req_row_mask),
      .req_mouse_x(req_mouse_x), .req_mouse_y(req_mouse_y),
      .req_read_word(req_read_word),
      .rsp_strobe(rsp_strobe), .rsp_is_write(rsp_is_write),
      .rsp_address(rsp_address), .rsp_write_word(rsp_write_word),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // One item transfer, with random idle cycles ahead of it; start stays high
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [3:0] row_index,
                            input logic [15:0] image, input logic [15:0] mask,
                            input logic [15:0] mx, input logic [15:0] my,
                            input logic [31:0] word);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_row_index <= row_index;
      req_row_image <= image;
      req_row_mask  <= mask;
      req_mouse_x   <= mx;
      req_mouse_y   <= my;
      req_read_word <= word;
      do @(posedge clock); while (busy);
   endtask

   task automatic do_load(input logic [3:0] row, input logic [15:0] image,
                          input logic [15:0] mask);
      send_item(FUNC_LOAD, row, image, mask, 16'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic do_draw(input logic [15:0] mx, input logic [15:0] my);
      send_item(FUNC_DRAW, 4'($urandom), 16'($urandom), 16'($urandom), mx, my, $urandom);
   endtask

   task automatic do_response(input logic [31:0] word);
      send_item(FUNC_RDRSP, 4'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), word);
   endtask

   task automatic do_restore();
      send_item(FUNC_RESTORE, 4'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), $urandom);
   endtask

   // Wait until every predicted request has come out and the block is quiet
   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int stride,
                            input logic [31:0] base, input int hx, input int hy);
      settle();
      write_reg(CSR_SCREEN_WIDTH, 32'(w));
      write_reg(CSR_SCREEN_HEIGHT, 32'(h));
      write_reg(CSR_ROW_STRIDE, 32'(stride));
      write_reg(CSR_FRAME_BASE, base);
      write_reg(CSR_HOTSPOT_X, 32'(hx));
      write_reg(CSR_HOTSPOT_Y, 32'(hy));
      cur_width  = w;
      cur_height = h;
   endtask

   // Mostly draw / response run / restore sequences, some loads and noise
   task automatic random_items(input int n);
      int          done, pick, k;
      logic [15:0] mx, my;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            do_load(4'($urandom), 16'($urandom), 16'($urandom));
            done++;
         end else if (pick < 80) begin
            if ($urandom_range(3) == 0) mx = 16'($urandom);
            else mx = 16'($urandom_range(cur_width + 24));
            if ($urandom_range(3) == 0) my = 16'($urandom);
            else my = 16'($urandom_range(cur_height + 24));
            do_draw(mx, my);
            k = ($urandom_range(9) < 7) ? ROWS : $urandom_range(ROWS - 1);
            for (int i = 0; i < k; i++) do_response($urandom);
            done += 1 + k;
            if ($urandom_range(9) < 7) begin
               do_restore();
               done++;
            end
         end else begin
            send_item(FUNC_W'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), $urandom);
            done++;
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_func      <= FUNC_LOAD;
      req_row_index <= 4'd0;
      req_row_image <= 16'd0;
      req_row_mask  <= 16'd0;
      req_mouse_x   <= 16'sd0;
      req_mouse_y   <= 16'sd0;
      req_read_word <= 32'd0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_SCREEN_WIDTH;
      csr_data      <= 32'd0;
      idle_pct      = 0;
      cur_width     = int'(RST_SCREEN_WIDTH);
      cur_height    = int'(RST_SCREEN_HEIGHT);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings and the built-in hand cursor
      do_restore();                          // nothing saved yet
      do_response(32'hFFFF_FFFF);            // nothing pending
      do_draw(16'h8000, 16'h8000);           // most negative, clamps to origin
      do_response(32'h0000_0000);
      do_response(32'hFFFF_FFFF);
      do_response(32'hA5A5_5A5A);
      do_restore();                          // partial run written back
      do_restore();                          // already restored
      do_draw(16'h7FFF, 16'h7FFF);           // clamps to bottom right
      do_response(32'h1234_5678);
      do_response(32'hFFFF_FFFF);
      do_draw(16'd100, 16'd50);              // drops the outstanding run
      do_response(32'hDEAD_BEEF);
      do_restore();
      do_load(4'd0, 16'hFFFF, 16'hFFFF);
      do_load(4'd15, 16'h0000, 16'h0000);
      do_load(4'd7, 16'hAAAA, 16'h5555);
      do_draw(16'd0, 16'd0);
      do_response(32'h0F0F_F0F0);
      do_restore();

      random_items(40);

      // upper extremes, base near the top of the address space
      configure(4095, 4095, 8192, 32'hFFFF_FF00, 15, 15);
      idle_pct = 52;
      random_items(45);

      // lower extremes
      configure(16, 16, 2, 32'h0000_0000, 0, 0);
      idle_pct = 0;
      random_items(35);

      // random setting
      configure($urandom_range(16, 4095), $urandom_range(16, 4095),
                2 * $urandom_range(1, 4096), $urandom,
                $urandom_range(15), $urandom_range(15));
      idle_pct = 25;
      random_items(35);

      // screen smaller than the sprite and an odd stride
      configure(5, 9, 13, 32'h0000_1001, 7, 3);
      idle_pct = 52;
      random_items(20);

      settle();
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/csu_pkg.sv
rtl/csu_ram.sv
rtl/csu_csr.sv
rtl/csu_sprite.sv
rtl/cursor_sprite_save_under.sv
tb/csu_request_checker.sv
tb/cursor_sprite_save_under_tb.sv
